// ===== src/brb_pkg.sv =====
// Shared types, operation codes and status codes of the byte ring buffer.
`default_nettype none

package brb_pkg;

  // Field widths of the stream items
  localparam int OP_W    = 3;
  localparam int LEN_W   = 12;
  localparam int BYTES_W = 64;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = 12;

  // Operation codes; status only and the unused codes fall outside these
  localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_W-1:0] OP_COMMIT  = 3'd3;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_ROOM  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_DATA  = 3'd3;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // latch the accepted input item
    logic decide;      // register the verdict, set up the byte cursor
    logic write_step;  // write one byte at the cursor
    logic read_step;   // issue one byte read at the cursor
    logic update;      // apply the pointer and count change
    logic emit;        // load the result register
  } brb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic go_write;    // accepted enqueue
    logic go_read;     // accepted dequeue or peek
    logic last_step;   // cursor is on the last byte of the transfer
  } brb_stat_t;

endpackage

`default_nettype wire

// ===== src/byte_ring_buffer.sv =====
// Byte ring buffer top level: stream ports, controller and datapath.
//
// One input item on the slave stream asks for one operation (operation in
// s_tuser): enqueue up to LANES bytes, dequeue or peek up to LANES bytes,
// advance the write or read position by a count, or report status only.
// Every item gives exactly one result item on the master stream, with the
// result status in m_tuser and the fill level, contiguous room and data
// before the wrap point, and the full and empty flags in m_tdata.
// At most SLOTS-1 bytes are held; one slot always stays empty.
// Items are handled one at a time. The byte store has one write and one
// read port, so bytes move one per cycle. After acceptance an item passes
// the check, update and emit states; an accepted enqueue adds a write step
// per byte, and an accepted dequeue or peek adds a read step per byte and a
// drain state for the registered read data; a rejected transfer adds none.
// The result register lets the next item be accepted while a result still
// waits; if the receiver stalls, the following item finishes its work and
// then holds until the result register is free.
// Reset empties the buffer: both positions and the fill count go to zero.
// The byte store itself is not cleared; no clearing pass is needed.
`default_nettype none

module byte_ring_buffer import brb_pkg::*; #(
  parameter int SLOTS = 4096,
  parameter int LANES = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  input  wire logic [79:0]  s_tdata,   // length[11:0], write_bytes[75:12], zero[79:76]
  input  wire logic [2:0]   s_tuser,   // operation[2:0]
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  output      logic [119:0] m_tdata,   // moved_count[11:0], read_bytes[75:12],
                                       // fill_level[87:76], contiguous_room[99:88],
                                       // contiguous_data[111:100], is_full[112],
                                       // is_empty[113], zero[119:114]
  output      logic [2:0]   m_tuser    // status[2:0]
);

  brb_cmd_t           cmd;
  brb_stat_t          stat;
  logic [CNT_W-1:0]   moved_count, fill_level, contiguous_room, contiguous_data;
  logic [BYTES_W-1:0] read_bytes;
  logic               is_full, is_empty;

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  brb_datapath #(
    .SLOTS (SLOTS),
    .LANES (LANES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .operation       (s_tuser),
    .length          (s_tdata[11:0]),
    .write_bytes     (s_tdata[75:12]),
    .status          (m_tuser),
    .moved_count     (moved_count),
    .read_bytes      (read_bytes),
    .fill_level      (fill_level),
    .contiguous_room (contiguous_room),
    .contiguous_data (contiguous_data),
    .is_full         (is_full),
    .is_empty        (is_empty)
  );

  // Pack the result fields
  assign m_tdata = {6'd0, is_empty, is_full, contiguous_data, contiguous_room,
                    fill_level, read_bytes, moved_count};

  // A rejected or status-only result moves nothing and returns no bytes
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_DONE)) |-> ((moved_count == '0) && (read_bytes == '0)))
    else $error("rejected result carries moved bytes");

  // The buffer is never reported full and empty at once
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(is_full && is_empty))
    else $error("result reports full and empty together");

  // An accepted item is checked in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> cmd.decide)
    else $error("accepted item not followed by its check");

  // No byte moves while the block takes input
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(cmd.write_step || cmd.read_step || cmd.update))
    else $error("byte transfer while idle");

endmodule

`default_nettype wire

// ===== src/brb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/brb_ctrl.sv =====
// Controller state machine that sequences one operation at a time.
`default_nettype none

module brb_ctrl import brb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  output      logic      out_valid,
  input  wire logic      out_ready,
  input  wire brb_stat_t stat,
  output      brb_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_WRITE  = 7'b0000100,
    S_READ   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_UPDATE = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.go_write) begin
          state_next = S_WRITE;
        end else if (stat.go_read) begin
          state_next = S_READ;
        end else begin
          state_next = S_UPDATE;
        end
      end
      S_WRITE: begin
        cmd.write_step = 1'b1;
        if (stat.last_step) begin
          state_next = S_UPDATE;
        end
      end
      S_READ: begin
        cmd.read_step = 1'b1;
        if (stat.last_step) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // wait for a free result register
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

`default_nettype wire

// ===== src/brb_datapath.sv =====
// Datapath: pointers, fill count, byte store, byte cursor and result register.
`default_nettype none

module brb_datapath import brb_pkg::*; #(
  parameter int SLOTS = 4096,
  parameter int LANES = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire brb_cmd_t           cmd,
  output      brb_stat_t          stat,
  input  wire logic [OP_W-1:0]    operation,
  input  wire logic [LEN_W-1:0]   length,
  input  wire logic [BYTES_W-1:0] write_bytes,
  output      logic [STAT_W-1:0]  status,
  output      logic [CNT_W-1:0]   moved_count,
  output      logic [BYTES_W-1:0] read_bytes,
  output      logic [CNT_W-1:0]   fill_level,
  output      logic [CNT_W-1:0]   contiguous_room,
  output      logic [CNT_W-1:0]   contiguous_data,
  output      logic               is_full,
  output      logic               is_empty
);

  localparam int AW = $clog2(SLOTS);
  localparam int WW = (AW > LEN_W) ? AW : LEN_W;
  localparam int SW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [AW-1:0] LAST_POS = AW'(SLOTS - 1);
  localparam logic [AW:0]   SLOTS_X  = (AW + 1)'(SLOTS);

  // Operation registers
  logic [OP_W-1:0]     op_q;
  logic [LEN_W-1:0]    len_q;
  logic [7:0][7:0]     wb_q;
  logic [STAT_W-1:0]   status_q;
  logic                ok_q;

  // Ring state
  logic [AW-1:0]       rpos, wpos, held;

  // Byte cursor
  logic [AW-1:0]       cursor;
  logic [SW-1:0]       step;
  logic                cap_pend;
  logic [2:0]          cap_idx;
  logic [7:0][7:0]     rb;
  logic [7:0]          ram_rdata;

  // Verdict
  logic                lanes_op, needs_room, xfer_op;
  logic [WW-1:0]       len_w, held_w, room_w;
  logic [STAT_W-1:0]   verdict;
  logic                verdict_ok;

  // Status fields
  logic [AW:0]         room_c, data_c;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] pos,
                                             input logic [AW-1:0] n);
    logic [AW:0] sum;
    sum = {1'b0, pos} + {1'b0, n};
    if (sum >= SLOTS_X) begin
      sum = sum - SLOTS_X;
    end
    return sum[AW-1:0];
  endfunction

  // Check the latched operation against the ring state
  always_comb begin
    lanes_op   = (op_q <= OP_PEEK);
    needs_room = (op_q == OP_ENQUEUE) || (op_q == OP_COMMIT);
    xfer_op    = (op_q <= OP_RELEASE);
    len_w      = WW'(len_q);
    held_w     = WW'(held);
    room_w     = WW'(LAST_POS - held);
    verdict    = ST_DONE;
    if (xfer_op) begin
      if (len_q == '0) begin
        verdict = ST_ZERO;
      end else if (lanes_op && (len_q > LEN_W'(LANES))) begin
        verdict = ST_TOO_LONG;
      end else if (needs_room && (len_w > room_w)) begin
        verdict = ST_NO_ROOM;
      end else if (!needs_room && (len_w > held_w)) begin
        verdict = ST_NO_DATA;
      end
    end
    verdict_ok = xfer_op && (verdict == ST_DONE);
  end

  assign stat.go_write  = verdict_ok && (op_q == OP_ENQUEUE);
  assign stat.go_read   = verdict_ok && ((op_q == OP_DEQUEUE) || (op_q == OP_PEEK));
  assign stat.last_step = (LEN_W'(step) == (len_q - LEN_W'(1)));

  // Latch the item and the verdict
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      len_q <= length;
      wb_q  <= write_bytes;
    end
    if (cmd.decide) begin
      status_q <= verdict;
      ok_q     <= verdict_ok;
    end
  end

  // Step the byte cursor and collect read bytes
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      cursor <= (op_q == OP_ENQUEUE) ? wpos : rpos;
      step   <= '0;
    end else if (cmd.write_step || cmd.read_step) begin
      cursor <= (cursor == LAST_POS) ? '0 : cursor + AW'(1);
      step   <= step + SW'(1);
    end
    cap_idx <= 3'(step);
    if (cmd.decide) begin
      rb <= '0;
    end else if (cap_pend) begin
      rb[cap_idx] <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_pend <= 1'b0;
    end else begin
      cap_pend <= cmd.read_step;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rpos <= '0;
      wpos <= '0;
      held <= '0;
    end else if (cmd.update && ok_q) begin
      case (op_q)
        OP_ENQUEUE, OP_COMMIT: begin
          wpos <= wrap_add(wpos, AW'(len_w));
          held <= held + AW'(len_w);
        end
        OP_DEQUEUE, OP_RELEASE: begin
          rpos <= wrap_add(rpos, AW'(len_w));
          held <= held - AW'(len_w);
        end
        default: begin
        end
      endcase
    end
  end

  brb_ram #(
    .WIDTH (8),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.write_step),
    .waddr (cursor),
    .wdata (wb_q[3'(step)]),
    .re    (cmd.read_step),
    .raddr (cursor),
    .rdata (ram_rdata)
  );

  // Contiguous room and data before the wrap point
  always_comb begin
    if (held >= LAST_POS) begin
      room_c = '0;
    end else if (wpos < rpos) begin
      room_c = {1'b0, rpos} - {1'b0, wpos} - (AW + 1)'(1);
    end else if (rpos == '0) begin
      room_c = SLOTS_X - {1'b0, wpos} - (AW + 1)'(1);
    end else begin
      room_c = SLOTS_X - {1'b0, wpos};
    end
    if (held == '0) begin
      data_c = '0;
    end else if (wpos <= rpos) begin
      data_c = SLOTS_X - {1'b0, rpos};
    end else begin
      data_c = {1'b0, wpos} - {1'b0, rpos};
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status          <= status_q;
      moved_count     <= ok_q ? len_q : '0;
      read_bytes      <= rb;
      fill_level      <= CNT_W'(held);
      contiguous_room <= CNT_W'(room_c);
      contiguous_data <= CNT_W'(data_c);
      is_full         <= (held == LAST_POS);
      is_empty        <= (held == '0);
    end
  end

endmodule

`default_nettype wire

// ===== tb/byte_ring_buffer_checker.sv =====
`timescale 1ns / 100ps
// Result checker of the byte ring buffer: predicts every result from the accepted items.
module byte_ring_buffer_checker import brb_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [79:0]  s_tdata,      // length[11:0], write_bytes[75:12], zero[79:76]
  input  logic [2:0]   s_tuser,      // operation[2:0]
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [119:0] m_tdata,      // moved_count[11:0], read_bytes[75:12],
                                     // fill_level[87:76], contiguous_room[99:88],
                                     // contiguous_data[111:100], is_full[112],
                                     // is_empty[113], zero[119:114]
  input  logic [2:0]   m_tuser,      // status[2:0]
  output int           fail_count,
  output int           outstanding
);

  localparam int SLOTS    = 4096;
  localparam int LANES    = 8;
  localparam int CAPACITY = SLOTS - 1;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   moved;
    logic [BYTES_W-1:0] rbytes;
    logic [CNT_W-1:0]   fill;
    logic [CNT_W-1:0]   room_run;
    logic [CNT_W-1:0]   data_run;
    logic               full;
    logic               empty;
  } ring_result_t;

  // Shadow copy of the ring
  logic [7:0]       ring_bytes [SLOTS];
  logic [CNT_W-1:0] rd_pos;
  logic [CNT_W-1:0] wr_pos;
  int               held;
  ring_result_t     awaited_results [$];

  initial begin
    fail_count  = 0;
    rd_pos      = '0;
    wr_pos      = '0;
    held        = 0;
  end

  // Apply one operation to the shadow ring and build the result it gives
  task automatic predict_result(input logic [OP_W-1:0] op, input int len,
                                input logic [BYTES_W-1:0] wbytes, output ring_result_t res);
    logic [CNT_W-1:0] slot;
    int               room;
    int               i;
    bit               lane_op;
    bit               room_op;
    res     = '0;
    res.status = ST_DONE;
    room    = CAPACITY - held;
    lane_op = (op == OP_ENQUEUE || op == OP_DEQUEUE || op == OP_PEEK);
    room_op = (op == OP_ENQUEUE || op == OP_COMMIT);
    if (lane_op || op == OP_COMMIT || op == OP_RELEASE) begin
      if (len == 0) begin
        res.status = ST_ZERO;
      end else if (lane_op && len > LANES) begin
        res.status = ST_TOO_LONG;
      end else if (room_op && len > room) begin
        res.status = ST_NO_ROOM;
      end else if (!room_op && len > held) begin
        res.status = ST_NO_DATA;
      end else begin
        res.moved = CNT_W'(len);
        // Gather from the read side before any pointer moves
        if (op == OP_DEQUEUE || op == OP_PEEK) begin
          for (i = 0; i < len; i++) begin
            slot = rd_pos + CNT_W'(i);
            res.rbytes[8*i +: 8] = ring_bytes[slot];
          end
        end
        if (op == OP_ENQUEUE) begin
          for (i = 0; i < len; i++) begin
            slot = wr_pos + CNT_W'(i);
            ring_bytes[slot] = wbytes[8*i +: 8];
          end
        end
        if (room_op) begin
          wr_pos = wr_pos + CNT_W'(len);
          held   = held + len;
        end else if (op != OP_PEEK) begin
          rd_pos = rd_pos + CNT_W'(len);
          held   = held - len;
        end
      end
    end
    // Free run up to the wrap point, one slot kept empty
    if (held >= CAPACITY)
      res.room_run = '0;
    else if (wr_pos < rd_pos)
      res.room_run = CNT_W'(int'(rd_pos) - int'(wr_pos) - 1);
    else if (rd_pos == '0)
      res.room_run = CNT_W'(SLOTS - 1 - int'(wr_pos));
    else
      res.room_run = CNT_W'(SLOTS - int'(wr_pos));
    // Held run up to the wrap point
    if (held == 0)
      res.data_run = '0;
    else if (wr_pos <= rd_pos)
      res.data_run = CNT_W'(SLOTS - int'(rd_pos));
    else
      res.data_run = CNT_W'(int'(wr_pos) - int'(rd_pos));
    res.fill  = CNT_W'(held);
    res.full  = (held == CAPACITY);
    res.empty = (held == 0);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Predict on input items, compare on result items
  always @(posedge clk) begin
    ring_result_t predicted;
    ring_result_t oldest;
    if (rst) begin
      rd_pos = '0;
      wr_pos = '0;
      held   = 0;
      awaited_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        predict_result(s_tuser, int'(s_tdata[LEN_W-1:0]), s_tdata[75:12], predicted);
        awaited_results.push_back(predicted);
      end
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: result expected none, got status %h data %h",
                   $time, m_tuser, m_tdata);
          fail_count++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("status", 64'(oldest.status), 64'(m_tuser));
          check_field("moved_count", 64'(oldest.moved), 64'(m_tdata[11:0]));
          check_field("read_bytes", oldest.rbytes, m_tdata[75:12]);
          check_field("fill_level", 64'(oldest.fill), 64'(m_tdata[87:76]));
          check_field("contiguous_room", 64'(oldest.room_run), 64'(m_tdata[99:88]));
          check_field("contiguous_data", 64'(oldest.data_run), 64'(m_tdata[111:100]));
          check_field("is_full", 64'(oldest.full), 64'(m_tdata[112]));
          check_field("is_empty", 64'(oldest.empty), 64'(m_tdata[113]));
          check_field("padding", 64'd0, 64'(m_tdata[119:114]));
        end
      end
    end
    outstanding <= awaited_results.size();
  end

endmodule

// ===== tb/byte_ring_buffer_test.sv =====
`timescale 1ns / 100ps
// Testbench top of the byte ring buffer: clock, reset, stimulus and verdict.
module byte_ring_buffer_test;
  import brb_pkg::*;

  localparam int SLOTS        = 4096;
  localparam int LANES        = 8;
  localparam int CAPACITY     = SLOTS - 1;
  localparam int MAX_LEN      = 4095;
  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 24;

  // Codes outside the package: status only and the two spare codes
  localparam logic [OP_W-1:0] OP_STATUS  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  logic         clk;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata  = '0;   // length[11:0], write_bytes[75:12], zero[79:76]
  logic [2:0]   s_tuser  = '0;   // operation[2:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;         // moved_count[11:0], read_bytes[75:12],
                                 // fill_level[87:76], contiguous_room[99:88],
                                 // contiguous_data[111:100], is_full[112],
                                 // is_empty[113], zero[119:114]
  logic [2:0]   m_tuser;         // status[2:0]

  int fail_count;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stuck_cycles   = 0;

  // Stimulus-side view of the ring: keeps reads off never-written slots
  logic [CNT_W-1:0] plan_rd   = '0;
  logic [CNT_W-1:0] plan_wr   = '0;
  int               plan_held = 0;
  bit               slot_written [SLOTS];

  byte_ring_buffer DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  byte_ring_buffer_checker checker_i (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .fail_count, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result side at random
  always @(posedge clk)
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic bit transfer_fits(logic [OP_W-1:0] op, int len);
    case (op)
      OP_ENQUEUE:          return len >= 1 && len <= LANES && len <= CAPACITY - plan_held;
      OP_COMMIT:           return len >= 1 && len <= CAPACITY - plan_held;
      OP_DEQUEUE, OP_PEEK: return len >= 1 && len <= LANES && len <= plan_held;
      OP_RELEASE:          return len >= 1 && len <= plan_held;
      default:             return 1'b0;
    endcase
  endfunction

  // Hand one item to the block; a read over unwritten slots becomes a release
  task automatic send_item(input logic [OP_W-1:0] op, input int len,
                           input logic [BYTES_W-1:0] payload);
    logic [OP_W-1:0]  code;
    logic [CNT_W-1:0] slot;
    bit               fits;
    int               i;
    code = op;
    fits = transfer_fits(code, len);
    if (fits && (code == OP_DEQUEUE || code == OP_PEEK)) begin
      for (i = 0; i < len; i++) begin
        slot = plan_rd + CNT_W'(i);
        if (!slot_written[slot])
          code = OP_RELEASE;
      end
    end
    if (fits) begin
      case (code)
        OP_ENQUEUE: begin
          for (i = 0; i < len; i++) begin
            slot = plan_wr + CNT_W'(i);
            slot_written[slot] = 1'b1;
          end
          plan_wr   = plan_wr + CNT_W'(len);
          plan_held = plan_held + len;
        end
        OP_COMMIT: begin
          plan_wr   = plan_wr + CNT_W'(len);
          plan_held = plan_held + len;
        end
        OP_DEQUEUE, OP_RELEASE: begin
          plan_rd   = plan_rd + CNT_W'(len);
          plan_held = plan_held - len;
        end
        default: ;
      endcase
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, payload, len[LEN_W-1:0]};
    s_tuser  <= code;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
  endtask

  // Hold off the sender until every result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
  endtask

  function automatic int lane_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)
      return 0;
    if (r < 10)
      return $urandom_range(LANES + 1, MAX_LEN);
    return $urandom_range(1, LANES);
  endfunction

  // Pointer advance: mostly within the limit, sometimes exactly it, sometimes anything
  function automatic int span_len(int limit);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)
      return 0;
    if (r < 20 || limit == 0)
      return $urandom_range(1, MAX_LEN);
    if (r < 28)
      return limit;
    if (r < 64)
      return $urandom_range(1, (limit < 16) ? limit : 16);
    return $urandom_range(1, limit);
  endfunction

  task automatic send_random_item();
    logic [BYTES_W-1:0] payload;
    int                 r;
    payload = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 30)
      send_item(OP_ENQUEUE, lane_len(), payload);
    else if (r < 52)
      send_item(OP_DEQUEUE, lane_len(), payload);
    else if (r < 62)
      send_item(OP_PEEK, lane_len(), payload);
    else if (r < 74)
      send_item(OP_COMMIT, span_len(CAPACITY - plan_held), payload);
    else if (r < 88)
      send_item(OP_RELEASE, span_len(plan_held), payload);
    else if (r < 94)
      send_item(OP_STATUS, $urandom_range(0, MAX_LEN), payload);
    else if (r < 97)
      send_item(OP_SPARE_A, $urandom_range(0, MAX_LEN), payload);
    else
      send_item(OP_SPARE_B, $urandom_range(0, MAX_LEN), payload);
  endtask

  initial begin
    int idle_by_phase [4];
    int stall_by_phase [4];
    int phase;
    int n;
    idle_by_phase  = '{0, 50, 0, 36};
    stall_by_phase = '{0, 0, 50, 36};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty buffer: status, reads and release rejected
    send_item(OP_STATUS, 0, '0);
    send_item(OP_DEQUEUE, 1, '0);
    send_item(OP_PEEK, 1, '0);
    send_item(OP_RELEASE, 1, '0);
    // Zero length and too long
    send_item(OP_ENQUEUE, 0, '1);
    send_item(OP_ENQUEUE, LANES + 1, '1);
    send_item(OP_ENQUEUE, MAX_LEN, '1);
    // Full-width transfers with all ones and all zeros
    send_item(OP_ENQUEUE, LANES, '1);
    send_item(OP_PEEK, LANES, '0);
    send_item(OP_DEQUEUE, LANES, '0);
    send_item(OP_ENQUEUE, LANES, '0);
    send_item(OP_DEQUEUE, 3, '1);
    send_item(OP_DEQUEUE, 5, '1);
    send_item(OP_DEQUEUE, MAX_LEN, '1);
    send_item(OP_RELEASE, MAX_LEN, '1);
    // Fill to capacity by a commit, then refuse more
    send_item(OP_COMMIT, 0, '0);
    send_item(OP_COMMIT, CAPACITY, '0);
    send_item(OP_ENQUEUE, 1, '1);
    send_item(OP_COMMIT, 1, '0);
    send_item(OP_SPARE_A, 0, '0);
    send_item(OP_SPARE_B, MAX_LEN, '1);
    send_item(OP_RELEASE, CAPACITY, '0);
    // Move both positions near the end, then transfer across the wrap point
    send_item(OP_COMMIT, SLOTS - 19, '0);
    send_item(OP_RELEASE, SLOTS - 19, '0);
    send_item(OP_ENQUEUE, LANES, 64'h8877_6655_4433_2211);
    send_item(OP_PEEK, LANES, '0);
    send_item(OP_DEQUEUE, LANES, '0);

    // Random items under each idling mix, with a full drain midway
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_by_phase[phase];
      recv_stall_pct = stall_by_phase[phase];
      for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
        if (n == RANDOM_ITEMS / 8)
          wait_drained();
        send_random_item();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
